[src/crt_pkg.sv]
// Package for the connection rate throttle: field widths, codes, FSM states.
// Used by the top, controller and datapath; depends on nothing.
`default_nettype none
package crt_pkg;
   localparam int TableEntriesDefault = 64;
   localparam int AddrWidth = 64;
   localparam int TimeWidth = 32;
   localparam int PeriodWidth = 16;
   localparam int LimitWidth = 8;
   localparam int ExpWidth = 7;
   localparam logic [TimeWidth-1:0] DefaultExpiry = 32'd15;
   localparam logic [ExpWidth-1:0] ExpiredMax = 7'd127;

   localparam logic [1:0] VerdictDenied = 2'd0;
   localparam logic [1:0] VerdictNew = 2'd1;
   localparam logic [1:0] VerdictAllowed = 2'd2;

   localparam logic CsrPeriod = 1'b0;
   localparam logic CsrLimit = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_READ, ST_WAIT, ST_DECIDE, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;      // clear scan pointer and flags, latch the item
      logic step;       // examine the slot at the pointer
      logic rd_hit;     // fetch the hit slot's attempt count
      logic commit;     // apply the connect decision
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic is_tick;
      logic disabled;
   } status_type;
endpackage
`default_nettype wire

[src/connection_rate_throttle_top.sv]
// Top level of the per-source connection rate throttle.
// Depends on crt_pkg, crt_ctrl, crt_datapath, crt_ram.
//
// Use: req_ carries one beat per item (a connect or a sweep tick), rsp_ returns
// exactly one verdict beat per item, csr_ writes period_seconds (index 0) and
// attempt_limit (index 1) while the block is idle.
// Sequence: an item walks the table slot by slot, a RAM read and then a compare
// per slot. A connect then reads the hit slot's attempt count and commits its
// decision; a tick answers after the scan, and with throttling disabled a
// connect skips the scan.
// The block holds one item at a time; req_tready is high only when idle, which
// is the cycle after the result beat is taken. The scan over the single-port
// entry RAM sets how long an item occupies the block.
// Reset clears the CSR registers, the scan pointer, all entry valid bits and
// the controller; the entry RAMs need no clearing. A stalled receiver holds the
// result beat stable and the block takes no new item until it is taken.
`default_nettype none
module connection_rate_throttle_top
   import crt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [167:0] req_tdata,  // address_high, address_low, exempt, now_seconds
   input  wire logic         req_tuser,  // mode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,  // verdict, table_full, expired_count
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_data
);
   logic [PeriodWidth-1:0] period_ff;
   logic [LimitWidth-1:0] limit_ff;
   cmd_type cmd;
   status_type status;
   logic [1:0] verdict;
   logic full;
   logic [ExpWidth-1:0] expired;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         limit_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CsrPeriod: period_ff <= csr_data;
            CsrLimit:  limit_ff  <= csr_data[LimitWidth-1:0];
            default:   period_ff <= period_ff;
         endcase
      end
   end

   crt_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .status
   );

   crt_datapath #(.TableEntries(TABLE_ENTRIES)) u_dp (
      .clock, .reset, .cmd, .status,
      .item_mode(req_tuser),
      .item_addr_high(req_tdata[63:0]),
      .item_addr_low(req_tdata[127:64]),
      .item_exempt(req_tdata[128]),
      .item_now(req_tdata[160:129]),
      .period(period_ff), .limit(limit_ff),
      .verdict, .table_full(full), .expired_count(expired)
   );

   assign rsp_tdata = {6'd0, expired, full, verdict};
endmodule
`default_nettype wire

[src/crt_ram.sv]
// Generic single-port RAM with a registered read.
// No dependencies.
`default_nettype none
module crt_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule
`default_nettype wire

[src/crt_datapath.sv]
// Datapath: entry table, scan pointer, match and expiry logic, result register.
// Depends on crt_pkg and crt_ram.
`default_nettype none
module crt_datapath
   import crt_pkg::*;
#(
   parameter int TableEntries = TableEntriesDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output status_type                   status,
   input  wire logic                    item_mode,
   input  wire logic [AddrWidth-1:0]    item_addr_high,
   input  wire logic [AddrWidth-1:0]    item_addr_low,
   input  wire logic                    item_exempt,
   input  wire logic [TimeWidth-1:0]    item_now,
   input  wire logic [PeriodWidth-1:0]  period,
   input  wire logic [LimitWidth-1:0]   limit,
   output logic [1:0]                   verdict,
   output logic                         table_full,
   output logic [ExpWidth-1:0]          expired_count
);
   localparam int IdxWidth = (TableEntries > 1) ? $clog2(TableEntries) : 1;
   localparam int CntWidth = $clog2(TableEntries + 1);
   localparam int RowWidth = 2 * AddrWidth + TimeWidth;
   localparam logic [CntWidth-1:0] LastIdx = CntWidth'(TableEntries - 1);

   logic [TableEntries-1:0] valid_ff;
   logic [CntWidth-1:0] ptr_ff, ptr_in;
   logic mode_ff, exempt_ff;
   logic [AddrWidth-1:0] ahi_ff, alo_ff;
   logic [TimeWidth-1:0] now_ff;
   logic hit_ff, free_ff;
   logic [IdxWidth-1:0] hit_idx_ff, free_idx_ff;
   logic [ExpWidth-1:0] freed_ff;
   logic [1:0] verdict_ff;
   logic full_ff;

   logic [IdxWidth-1:0] ptr_idx, row_addr, cnt_addr;
   logic row_we, cnt_we;
   logic [RowWidth-1:0] row_wdata, row_rdata;
   logic [LimitWidth-1:0] cnt_wdata, cnt_rdata;
   logic [TimeWidth-1:0] expiry, age;
   logic slot_valid, slot_match, slot_old;
   logic [LimitWidth:0] cnt_next;

   assign ptr_idx = ptr_ff[IdxWidth-1:0];

   // The row RAM is read at the pointer; a stepped slot compares last cycle's read.
   // The pointer holds the slot being compared; the read address is the pointer
   // itself, and the read is issued in the controller's read state.
   assign row_addr  = cmd.commit ? free_idx_ff : ptr_idx;
   assign row_we    = cmd.commit && !hit_ff && free_ff;
   assign row_wdata = {ahi_ff, alo_ff, now_ff};

   assign cnt_addr  = cmd.rd_hit ? hit_idx_ff : (hit_ff ? hit_idx_ff : free_idx_ff);
   assign cnt_next  = {1'b0, cnt_rdata} + (LimitWidth+1)'(1);
   assign cnt_we    = cmd.commit && ((!hit_ff && free_ff) ||
                      (hit_ff && !exempt_ff && cnt_next <= {1'b0, limit}));
   assign cnt_wdata = hit_ff ? cnt_next[LimitWidth-1:0] : LimitWidth'(1);

   crt_ram #(.Width(RowWidth), .Depth(TableEntries)) u_row_ram (
      .clock, .we(row_we), .addr(row_addr), .wdata(row_wdata), .rdata(row_rdata)
   );
   crt_ram #(.Width(LimitWidth), .Depth(TableEntries)) u_cnt_ram (
      .clock, .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
   );

   assign expiry     = (period != '0) ? TimeWidth'(period) : DefaultExpiry;
   assign age        = now_ff - row_rdata[TimeWidth-1:0];
   assign slot_valid = valid_ff[ptr_idx];
   assign slot_match = slot_valid && row_rdata[RowWidth-1:TimeWidth] == {ahi_ff, alo_ff};
   assign slot_old   = slot_valid && age > expiry;

   assign status.scan_done = (ptr_ff == LastIdx);
   assign status.is_tick   = mode_ff;
   assign status.disabled  = (period == '0) || (limit == '0);

   assign ptr_in = cmd.start ? '0 : (cmd.step ? ptr_ff + CntWidth'(1) : ptr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         ptr_ff <= ptr_in;
         if (cmd.step && mode_ff && slot_old) begin
            valid_ff[ptr_idx] <= 1'b0;
         end
         if (row_we) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff   <= item_mode;
         ahi_ff    <= item_addr_high;
         alo_ff    <= item_addr_low;
         exempt_ff <= item_exempt;
         now_ff    <= item_now;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
         freed_ff  <= '0;
         verdict_ff <= VerdictAllowed;
         full_ff   <= 1'b0;
      end else if (cmd.step) begin
         if (!mode_ff) begin
            if (slot_match && !hit_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= ptr_idx;
            end
            if (!slot_valid && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= ptr_idx;
            end
         end else if (slot_old && freed_ff != ExpiredMax) begin
            freed_ff <= freed_ff + ExpWidth'(1);
         end
      end else if (cmd.commit) begin
         if (hit_ff) begin
            if (!exempt_ff && cnt_next > {1'b0, limit}) begin
               verdict_ff <= VerdictDenied;
            end
         end else if (free_ff) begin
            verdict_ff <= VerdictNew;
         end else begin
            full_ff <= 1'b1;
         end
      end
   end

   assign verdict       = verdict_ff;
   assign table_full    = full_ff;
   assign expired_count = mode_ff ? freed_ff : '0;
endmodule
`default_nettype wire

[src/crt_ctrl.sv]
// Controller state machine: sequences the table scan and the result beat.
// Depends on crt_pkg.
`default_nettype none
module crt_ctrl
   import crt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output cmd_type         cmd,
   input  wire status_type status
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_READ;
         ST_READ:   state_in = (status.disabled && !status.is_tick) ? ST_OUT : ST_SCAN;
         ST_SCAN:   state_in = status.scan_done
                               ? (status.is_tick ? ST_OUT : ST_WAIT) : ST_READ;
         ST_WAIT:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_OUT;
         ST_OUT:    if (rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE:   begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_SCAN:   cmd.step = 1'b1;
         ST_WAIT:   cmd.rd_hit = 1'b1;
         ST_DECIDE: cmd.commit = 1'b1;
         ST_OUT:    rsp_tvalid = 1'b1;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.step, cmd.rd_hit, cmd.commit}))
      else $error("several commands at once");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");
   a_commit_out: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit not followed by a result");
`endif
endmodule
`default_nettype wire

[verif/tb_connection_rate_throttle_top.sv]
// Testbench for connection_rate_throttle_top: directed and random connects and sweep ticks.
// A scoreboard class mirrors the throttle table and checks each verdict beat.
// Depends on crt_pkg and the RTL of the block only.
`timescale 1ns / 1ps
`default_nettype none

class throttle_scoreboard;
   localparam int Slots = 64;
   bit             slot_used [Slots];
   bit [63:0]      slot_addr_high [Slots];
   bit [63:0]      slot_addr_low [Slots];
   bit [31:0]      slot_first_seen [Slots];
   bit [7:0]       slot_attempts [Slots];
   bit [15:0]      period;
   bit [7:0]       limit;
   bit [9:0]       pending_verdicts [$];
   int             mismatches;

   function void set_register(bit index, bit [15:0] value);
      if (index == crt_pkg::CsrPeriod) period = value;
      else limit = value[7:0];
   endfunction

   function int used_slots();
      int n;
      n = 0;
      foreach (slot_used[i]) n += slot_used[i];
      return n;
   endfunction

   function void note_item(bit is_tick, bit [63:0] ahi, bit [63:0] alo, bit exempt,
                           bit [31:0] now);
      bit [1:0]  verdict;
      bit        full;
      bit [6:0]  freed;
      bit [31:0] max_age;
      int        hit;
      int        free_slot;
      verdict = crt_pkg::VerdictAllowed;
      full = 0;
      freed = 0;
      hit = -1;
      free_slot = -1;
      if (is_tick) begin
         max_age = (period != 0) ? {16'd0, period} : crt_pkg::DefaultExpiry;
         for (int i = 0; i < Slots; i++) begin
            if (slot_used[i] && (now - slot_first_seen[i]) > max_age) begin
               slot_used[i] = 0;
               if (freed < crt_pkg::ExpiredMax) freed++;
            end
         end
      end else if (period != 0 && limit != 0) begin
         for (int i = 0; i < Slots; i++) begin
            if (slot_used[i]) begin
               if (hit < 0 && slot_addr_high[i] == ahi && slot_addr_low[i] == alo) hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit < 0) begin
            if (free_slot < 0) begin
               full = 1;
            end else begin
               slot_used[free_slot] = 1;
               slot_addr_high[free_slot] = ahi;
               slot_addr_low[free_slot] = alo;
               slot_first_seen[free_slot] = now;
               slot_attempts[free_slot] = 1;
               verdict = crt_pkg::VerdictNew;
            end
         end else if (!exempt) begin
            if ({1'b0, slot_attempts[hit]} + 9'd1 > {1'b0, limit})
               verdict = crt_pkg::VerdictDenied;
            else
               slot_attempts[hit]++;
         end
      end
      pending_verdicts.push_back({freed, full, verdict});
   endfunction

   function void check_result(bit [15:0] beat);
      bit [9:0] exp_beat;
      if (pending_verdicts.size() == 0) begin
         $error("result beat with no item pending: %h", beat);
         mismatches++;
         return;
      end
      exp_beat = pending_verdicts.pop_front();
      if (beat[1:0] != exp_beat[1:0]) begin
         $error("verdict expected %0d actual %0d", exp_beat[1:0], beat[1:0]);
         mismatches++;
      end
      if (beat[2] != exp_beat[2]) begin
         $error("table_full expected %0d actual %0d", exp_beat[2], beat[2]);
         mismatches++;
      end
      if (beat[9:3] != exp_beat[9:3]) begin
         $error("expired_count expected %0d actual %0d", exp_beat[9:3], beat[9:3]);
         mismatches++;
      end
      if (beat[15:10] != 0) begin
         $error("rsp_tdata padding expected 0 actual %0h", beat[15:10]);
         mismatches++;
      end
   endfunction
endclass

module tb_connection_rate_throttle_top;
   import crt_pkg::*;

   localparam longint CycleLimit = 4_000_000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [15:0]  rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic         csr_index = 0;
   logic [15:0]  csr_data = '0;

   throttle_scoreboard board = new();
   longint cycle_count = 0;
   bit [31:0] clock_now = 1000;
   bit [63:0] known_high [8];
   bit [63:0] known_low [8];

   connection_rate_throttle_top dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: random stalls, check on every accepted beat.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata);
      end
   end

   // Leaves csr_valid high; the caller drops it after its last write.
   task automatic write_register(bit index, bit [15:0] value);
      csr_valid <= 1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_register(index, value);
   endtask

   // Leaves req_tvalid high after the accepted beat; it is dropped before an
   // idle gap or by drain, so back-to-back beats need only one assignment.
   task automatic send_item(bit is_tick, bit [63:0] ahi, bit [63:0] alo, bit exempt,
                            bit [31:0] now);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= is_tick;
      req_tdata <= {7'd0, now, exempt, alo, ahi};
      do @(posedge clock); while (!req_tready);
      board.note_item(is_tick, ahi, alo, exempt, now);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_both(bit [15:0] period, bit [7:0] limit);
      drain();
      write_register(CsrPeriod, period);
      write_register(CsrLimit, {8'd0, limit});
      csr_valid <= 0;
   endtask

   // Connect from a small pool of sources so repeats and denials happen often.
   task automatic random_connect();
      bit [63:0] ahi;
      bit [63:0] alo;
      int k;
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 4) == 0) begin
         ahi = {$urandom, $urandom};
         alo = {$urandom, $urandom};
      end else begin
         ahi = known_high[k];
         alo = known_low[k];
      end
      clock_now += $urandom_range(0, 3);
      send_item(0, ahi, alo, $urandom_range(0, 5) == 0, clock_now);
   endtask

   initial begin
      bit [15:0] period;
      bit [7:0]  limit;
      foreach (known_high[i]) begin
         known_high[i] = (i < 3) ? 64'd0 : {$urandom, $urandom};
         known_low[i] = {$urandom, $urandom};
      end
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Disabled throttling, then extremes of the fields.
      send_item(0, '1, '1, 1, '1);
      send_item(1, '0, '0, 0, 32'd100);
      set_both(16'd10, 8'd0);
      send_item(0, 64'd5, 64'd5, 0, 32'd0);
      set_both(16'd10, 8'd2);
      send_item(0, '1, '1, 0, 32'hFFFF_FFF0);
      send_item(0, '1, '1, 0, 32'hFFFF_FFF1);
      send_item(0, '1, '1, 0, 32'hFFFF_FFF2);
      send_item(0, '1, '1, 1, 32'hFFFF_FFF3);
      set_both(16'd10, 8'd1);
      send_item(0, '1, '1, 0, 32'hFFFF_FFF4);
      // Age wraps past zero: the tick at time 0 sees an age above the period and frees the entry.
      send_item(1, '1, '1, 1, 32'd0);
      send_item(1, '0, '0, 0, 32'd1);
      // Fill the table, then overflow it.
      set_both(16'd65535, 8'd255);
      for (int i = 0; i < 66; i++) send_item(0, 64'd0, 64'(i), 0, 32'd50);
      send_item(0, 64'd0, 64'd3, 0, 32'd51);
      set_both(16'd0, 8'd255);
      send_item(1, '0, '0, 0, 32'd65);
      send_item(1, '0, '0, 0, 32'd66);

      for (int n = 0; n < 1800; n++) begin
         if (n % 150 == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  period = 16'($urandom_range(1, 20));
                  limit = 8'($urandom_range(1, 4));
               end
               1: begin period = 16'hFFFF; limit = 8'hFF; end
               2: begin period = 16'($urandom); limit = 8'($urandom); end
               default: begin period = $urandom_range(0, 1) ? 16'd0 : 16'd1;
                  limit = $urandom_range(0, 1) ? 8'd0 : 8'd1; end
            endcase
            set_both(period, limit);
         end
         if ($urandom_range(0, 9) == 0) begin
            clock_now += $urandom_range(0, 20);
            if ($urandom_range(0, 30) == 0) clock_now = $urandom;
            send_item(1, {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom),
                      clock_now);
         end else begin
            random_connect();
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (board.mismatches == 0 && board.pending_verdicts.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
